// ===== hw/rtl/assert_macros.svh =====
// assertion macros of the top-level rtl file of the detector
// no dependencies; taken in by `include where a module asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ATD_ASSERT(LBL, CLK, RSTN, PROP, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) else $error(MSG);

// clocked assertion that also holds through reset
`define ATD_ASSERT_ALWAYS(LBL, CLK, PROP, MSG) \
  LBL: assert property (@(posedge CLK) PROP) else $error(MSG);

`endif

// ===== hw/rtl/atd_pkg.sv =====
// types, constants and microcode encodings of the adaptive threshold detector
// no dependencies; imported by the interfaces, the top level and the sequencer
package atd_pkg;

  // window length, must be a power of two (mean is a shift)
  localparam int WINDOW_LEN = 64;
  localparam int WIN_SHIFT  = $clog2(WINDOW_LEN);
  localparam int WIN_CNT_W  = $clog2(WINDOW_LEN + 1);

  localparam int SAMPLE_W   = 12;
  localparam int Q_W        = 28;
  localparam int FRAC_W     = 16;
  localparam int K_W        = 17;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int MARGIN_W   = 29;
  localparam int PCNT_W     = 16;
  localparam int SUM_W      = Q_W + WIN_SHIFT;
  localparam int LIMIT_W    = Q_W + 2;

  // shared multiplier: signed difference or level times unsigned coefficient or gain
  localparam int MUL_A_W    = Q_W + 1;
  localparam int MUL_B_W    = K_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int BLEND_W    = PROD_W - FRAC_W;
  localparam int LVL_W      = PROD_W - GAIN_FRAC;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MARGIN_W;

  localparam logic [K_W-1:0]   K_ONE     = K_W'(1) << FRAC_W;
  localparam logic [Q_W-1:0]   Q_MAX     = '1;
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1) << GAIN_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K_FAST,
    CFG_K_SLOW,
    CFG_K_THR,
    CFG_GAIN,
    CFG_MARGIN,
    CFG_PLIMIT,
    CFG_ENABLE,
    CFG_INIT_THR
  } cfg_reg_t;

  // datapath operation of one microcode step
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MUL_FAST,
    OP_ADD_FAST,
    OP_MUL_SLOW,
    OP_ADD_SLOW,
    OP_LEARN,
    OP_DIFF,
    OP_MUL_GAIN,
    OP_LEVEL,
    OP_MUL_THR,
    OP_ADD_THR,
    OP_LIMIT,
    OP_DETECT,
    OP_OUT
  } op_t;

  // sequencing of one microcode step
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_WAIT_IN,
    BR_WAIT_OUT,
    BR_SKIP_WIN
  } br_t;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_DETECT = 4'd12;

  typedef struct packed {
    op_t   op;
    br_t   br;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic learn;
    logic win_full;
  } seq_status_t;

endpackage

// ===== hw/rtl/atd_in_if.sv =====
// sample channel of the detector: valid, ready and one 12-bit sample
// depends on atd_pkg
interface atd_in_if
  import atd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/atd_out_if.sv =====
// result channel of the detector: averages, threshold and detect flag
// depends on atd_pkg
interface atd_out_if
  import atd_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [Q_W-1:0] fast_value;
  logic [Q_W-1:0] slow_value;
  logic [Q_W-1:0] threshold_level;
  logic           detect;

  modport source (output valid, output fast_value, output slow_value,
                  output threshold_level, output detect, input ready);
  modport sink   (input valid, input fast_value, input slow_value,
                  input threshold_level, input detect, output ready);
endinterface

// ===== hw/rtl/adaptive_threshold_detector_unit.sv =====
// top level of the adaptive threshold detector: config registers and datapath
// depends on atd_pkg, atd_in_if, atd_out_if, atd_seq and assert_macros.svh
//
//   channel  dir  payload                                          handshake
//   in_ch    in   sample[11:0]                                     valid/ready
//   out_ch   out  fast_value, slow_value, threshold_level, detect  valid/ready
//   cfg_*    in   cfg_index[2:0], cfg_data[28:0]                   cfg_we only
//
// a word runs idle, fast and slow blend, learn, detect, out, plus any out stall
// words ending a window add level and threshold steps, on one shared multiplier
// the next word is taken in the cycle after its result is loaded into out_ch
// synchronous active-low reset; config and state go to their reset values
// a held result stays in the output register while the next word is worked on
`include "assert_macros.svh"

module adaptive_threshold_detector_unit
  import atd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  atd_in_if.sink                in_ch,
  atd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [K_W-1:0]      k_fast_r, k_slow_r, k_thr_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [PCNT_W-1:0]   plimit_r;
  logic                enable_r;

  // filter and window state
  logic [SAMPLE_W-1:0]  x_r;
  logic [Q_W-1:0]       fast_r, slow_r, peak_r, thr_r, level_r;
  logic [SUM_W-1:0]     sum_r;
  logic [WIN_CNT_W-1:0] win_cnt_r;
  logic [PCNT_W-1:0]    pcnt_r;
  logic                 flag_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [LIMIT_W-1:0] limit_r;

  // output register
  logic           out_valid_r;
  logic [Q_W-1:0] out_fast_r, out_slow_r, out_thr_r;
  logic           out_det_r;

  uword_t      uw;
  seq_status_t status;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic [Q_W-1:0]            blend_y, blend_q, mean;
  logic [BLEND_W-1:0]        blend_sum;
  logic [LVL_W-1:0]          lvl_sum;
  logic [Q_W-1:0]            lvl_sat;
  logic signed [LIMIT_W-1:0] limit_nxt;
  logic signed [LIMIT_W-1:0] slow_s;
  logic                      learn, above, out_free;
  logic [K_W-1:0]            k_wr;
  cfg_reg_t                  cfg_sel;

  atd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status_i (status),
    .uword_o  (uw)
  );

  // ---------------------------------------------------------------- control
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (uw.op == OP_IDLE);

  assign slow_s = $signed({2'b00, slow_r});
  assign learn  = (slow_s < limit_r) || !enable_r;
  assign above  = (slow_s > limit_r) && enable_r;

  always_comb begin
    status.in_valid = in_ch.valid;
    status.out_free = out_free;
    status.learn    = learn;
    status.win_full = (win_cnt_r == WIN_CNT_W'(WINDOW_LEN - 1));
  end

  // ------------------------------------------------------ shared multiplier
  // blend is y + ((x - y) * k) >>> 16, exact against the two-term form
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.op)
      OP_MUL_FAST: begin
        mul_a = $signed({1'b0, x_r, {FRAC_W{1'b0}}}) - $signed({1'b0, fast_r});
        mul_b = $signed({1'b0, k_fast_r});
      end
      OP_MUL_SLOW: begin
        mul_a = $signed({1'b0, fast_r}) - $signed({1'b0, slow_r});
        mul_b = $signed({1'b0, k_slow_r});
      end
      OP_MUL_GAIN: begin
        mul_a = $signed({1'b0, level_r});
        mul_b = $signed({2'b00, gain_r});
      end
      OP_MUL_THR: begin
        mul_a = $signed({1'b0, level_r}) - $signed({1'b0, thr_r});
        mul_b = $signed({1'b0, k_thr_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // shared blend adder, result always lies between the two inputs
  always_comb begin
    case (uw.op)
      OP_ADD_FAST: blend_y = fast_r;
      OP_ADD_SLOW: blend_y = slow_r;
      default:     blend_y = thr_r;
    endcase
  end

  assign blend_sum = {{(BLEND_W - Q_W){1'b0}}, blend_y} + prod_r[PROD_W-1:FRAC_W];
  assign blend_q   = blend_sum[Q_W-1:0];

  // window mean and gained level
  assign mean    = sum_r[SUM_W-1:WIN_SHIFT];
  assign lvl_sum = prod_r[PROD_W-1:GAIN_FRAC] + {{(LVL_W - Q_W){1'b0}}, mean};
  assign lvl_sat = (lvl_sum > {{(LVL_W - Q_W){1'b0}}, Q_MAX}) ? Q_MAX : lvl_sum[Q_W-1:0];

  // threshold plus margin, wide enough never to wrap
  assign limit_nxt = $signed({2'b00, thr_r}) + $signed({margin_r[MARGIN_W-1], margin_r});

  // ---------------------------------------------------------- config port
  assign cfg_sel = cfg_reg_t'(cfg_index);
  // coefficients above one are held at one
  assign k_wr = (cfg_data[K_W-1:0] > K_ONE) ? K_ONE : cfg_data[K_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_fast_r <= K_ONE;
      k_slow_r <= K_ONE;
      k_thr_r  <= K_ONE;
      gain_r   <= GAIN_RST;
      margin_r <= '0;
      plimit_r <= '0;
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        CFG_K_FAST:   k_fast_r <= k_wr;
        CFG_K_SLOW:   k_slow_r <= k_wr;
        CFG_K_THR:    k_thr_r  <= k_wr;
        CFG_GAIN:     gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_MARGIN:   margin_r <= cfg_data[MARGIN_W-1:0];
        CFG_PLIMIT:   plimit_r <= cfg_data[PCNT_W-1:0];
        CFG_ENABLE:   enable_r <= cfg_data[0];
        CFG_INIT_THR: ;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (in_ch.valid && in_ch.ready) begin
      x_r <= in_ch.sample;
    end
    if (uw.op == OP_ADD_SLOW || uw.op == OP_LIMIT) begin
      limit_r <= limit_nxt;
    end
    if (uw.op == OP_DIFF) begin
      level_r <= (peak_r > mean) ? peak_r - mean : '0;
    end else if (uw.op == OP_LEVEL) begin
      level_r <= lvl_sat;
    end
  end

  // ---------------------------------------------------------- state regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r    <= '0;
      slow_r    <= '0;
      sum_r     <= '0;
      win_cnt_r <= '0;
      peak_r    <= '0;
      thr_r     <= Q_MAX;
      pcnt_r    <= '0;
      flag_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_sel == CFG_INIT_THR) begin
        thr_r <= cfg_data[Q_W-1:0];
      end else if (uw.op == OP_ADD_THR) begin
        thr_r <= blend_q;
      end
      case (uw.op)
        OP_ADD_FAST: fast_r <= blend_q;
        OP_ADD_SLOW: slow_r <= blend_q;
        OP_LEARN: begin
          if (learn) begin
            flag_r <= 1'b0;
            pcnt_r <= '0;
            sum_r  <= sum_r + {{(SUM_W - Q_W){1'b0}}, slow_r};
            if (peak_r < slow_r) begin
              peak_r <= slow_r;
            end
            // window full: count restarts, sum and peak clear after the level
            win_cnt_r <= status.win_full ? '0 : win_cnt_r + WIN_CNT_W'(1);
          end
        end
        OP_ADD_THR: begin
          sum_r  <= '0;
          peak_r <= '0;
        end
        OP_DETECT: begin
          if (above) begin
            if (pcnt_r >= plimit_r) begin
              flag_r <= 1'b1;
            end else begin
              pcnt_r <= pcnt_r + PCNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- output reg
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.op == OP_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_OUT && out_free) begin
      out_fast_r <= fast_r;
      out_slow_r <= slow_r;
      out_thr_r  <= thr_r;
      out_det_r  <= flag_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.fast_value      = out_fast_r;
  assign out_ch.slow_value      = out_slow_r;
  assign out_ch.threshold_level = out_thr_r;
  assign out_ch.detect          = out_det_r;

  // ---------------------------------------------------------- assertions
  `ATD_ASSERT(a_one_word_in_flight, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "second word taken while one is in work")
  `ATD_ASSERT(a_window_bound, clk, rst_n, win_cnt_r < WIN_CNT_W'(WINDOW_LEN), "window count past window length")
  `ATD_ASSERT(a_detect_needs_enable, clk, rst_n, $rose(flag_r) |-> enable_r, "detect raised with detection disabled")
  `ATD_ASSERT(a_out_from_program, clk, rst_n, $rose(out_valid_r) |-> $past(uw.op == OP_OUT), "result shown outside the output step")

endmodule

// ===== hw/rtl/atd_seq.sv =====
// microcode sequencer: step counter, control store and branch logic
// depends on atd_pkg
module atd_seq
  import atd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  seq_status_t status_i,
  output uword_t      uword_o
);

  step_t step_r, step_nxt;
  uword_t uw;

  // control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{op: OP_IDLE, br: BR_WAIT_IN, target: ST_IDLE};
    unique case (s)
      4'd0:    w = '{op: OP_IDLE,     br: BR_WAIT_IN,  target: ST_IDLE};
      4'd1:    w = '{op: OP_MUL_FAST, br: BR_NEXT,     target: ST_IDLE};
      4'd2:    w = '{op: OP_ADD_FAST, br: BR_NEXT,     target: ST_IDLE};
      4'd3:    w = '{op: OP_MUL_SLOW, br: BR_NEXT,     target: ST_IDLE};
      4'd4:    w = '{op: OP_ADD_SLOW, br: BR_NEXT,     target: ST_IDLE};
      4'd5:    w = '{op: OP_LEARN,    br: BR_SKIP_WIN, target: ST_DETECT};
      4'd6:    w = '{op: OP_DIFF,     br: BR_NEXT,     target: ST_IDLE};
      4'd7:    w = '{op: OP_MUL_GAIN, br: BR_NEXT,     target: ST_IDLE};
      4'd8:    w = '{op: OP_LEVEL,    br: BR_NEXT,     target: ST_IDLE};
      4'd9:    w = '{op: OP_MUL_THR,  br: BR_NEXT,     target: ST_IDLE};
      4'd10:   w = '{op: OP_ADD_THR,  br: BR_NEXT,     target: ST_IDLE};
      4'd11:   w = '{op: OP_LIMIT,    br: BR_NEXT,     target: ST_IDLE};
      4'd12:   w = '{op: OP_DETECT,   br: BR_NEXT,     target: ST_IDLE};
      4'd13:   w = '{op: OP_OUT,      br: BR_WAIT_OUT, target: ST_IDLE};
      default: w = '{op: OP_IDLE,     br: BR_WAIT_IN,  target: ST_IDLE};
    endcase
    return w;
  endfunction

  always_comb begin
    uw = ucode(step_r);
  end

  always_comb begin
    step_nxt = step_r;
    unique case (uw.br)
      BR_NEXT:     step_nxt = step_r + step_t'(1);
      BR_WAIT_IN:  step_nxt = status_i.in_valid ? step_r + step_t'(1) : step_r;
      BR_WAIT_OUT: step_nxt = status_i.out_free ? uw.target : step_r;
      BR_SKIP_WIN: begin
        step_nxt = (status_i.learn && status_i.win_full) ? step_r + step_t'(1)
                                                         : uw.target;
      end
      default:     step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign uword_o = uw;

endmodule
